// ----- sv/complex_vector_peak_normalize_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the complex vector peak normalizer
// Shared same-cycle and next-cycle implication property forms.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_VECTOR_PEAK_NORMALIZE_TOP_ASSERT_SVH
`define COMPLEX_VECTOR_PEAK_NORMALIZE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CVPN_ASSERT_NOW(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CVPN_ASSERT_NEXT(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/cvpn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvpn_pkg
// Widths, step counts and sequencer states of the peak normalizer.
// ----------------------------------------------------------------------------
package cvpn_pkg;

    // Buffer depth and derived index widths.
    localparam int MAX_LENGTH = 64;
    localparam int ADDR_W     = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int CNT_W      = $clog2(MAX_LENGTH + 1);

    // Field widths.
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 16;
    localparam int SCALE_W  = 32;
    localparam int SQ_W     = 32;
    localparam int PROD_W   = 47;

    // Magnitude unit steps: two squaring steps, then sixteen root steps.
    localparam int MAG_STEP_W = 5;
    localparam logic [MAG_STEP_W-1:0] STEP_SQ_RE    = 5'd0;
    localparam logic [MAG_STEP_W-1:0] STEP_SQ_IM    = 5'd1;
    localparam logic [MAG_STEP_W-1:0] STEP_ROOT_END = 5'd17;
    localparam logic [SQ_W-2:0]       ROOT_BIT_INIT = 31'h4000_0000;

    // Reciprocal unit: one quotient bit per step.
    localparam int DIV_STEP_W = $clog2(SCALE_W);
    localparam logic [DIV_STEP_W-1:0] DIV_STEP_END  = DIV_STEP_W'(SCALE_W - 1);
    localparam logic [SCALE_W-1:0]    RECIP_NUM     = 32'h8000_0000;

    // Saturation limits.
    localparam logic [PROD_W-17:0] SAT_POS_MAG = 31'd32767;
    localparam logic [PROD_W-17:0] SAT_NEG_MAG = 31'd32768;

    // Top level sequencer.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAG,
        ST_DIV,
        ST_RD,
        ST_MUL_RE,
        ST_MUL_IM,
        ST_SAT,
        ST_OUT
    } state_t;

    // Control group from the sequencer to the datapath.
    typedef struct packed {
        logic in_ready;
        logic mag_start;
        logic div_start;
        logic rd_en;
        logic sel_im;
        logic load_re;
        logic load_im;
    } ctrl_t;

endpackage

// ----- sv/cvpn_mag.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvpn_mag
// Iterative magnitude unit: squares re and im on one shared multiplier,
// then takes the truncated square root one result bit per step.
// ----------------------------------------------------------------------------
module cvpn_mag
    import cvpn_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [SAMPLE_W-1:0] re,
    input  logic signed [SAMPLE_W-1:0] im,
    output logic                       done,
    output logic [MAG_W-1:0]           mag
);

    logic                       busy_reg;
    logic                       busy_next;
    logic                       done_reg;
    logic                       done_next;
    logic [MAG_STEP_W-1:0]      step_reg;
    logic [MAG_STEP_W-1:0]      step_next;
    logic signed [SAMPLE_W-1:0] re_reg;
    logic signed [SAMPLE_W-1:0] im_reg;
    logic [SQ_W-1:0]            x_reg;
    logic [SQ_W-1:0]            x_next;
    logic [SQ_W-1:0]            root_reg;
    logic [SQ_W-1:0]            root_next;
    logic [SQ_W-2:0]            one_reg;
    logic [SQ_W-2:0]            one_next;
    logic signed [SAMPLE_W-1:0] mul_op;
    logic signed [SQ_W-1:0]     square;
    logic [SQ_W-1:0]            trial;

    // Shared squarer: re in the first step, im in the second.
    assign mul_op = (step_reg == STEP_SQ_RE) ? re_reg : im_reg;
    assign square = mul_op * mul_op;
    assign trial  = root_reg + SQ_W'(one_reg);

    // Next values of the step sequence.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        x_next    = x_reg;
        root_next = root_reg;
        one_next  = one_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_SQ_RE;
            x_next    = '0;
            root_next = '0;
            one_next  = ROOT_BIT_INIT;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + MAG_STEP_W'(1);
            if (step_reg == STEP_SQ_RE || step_reg == STEP_SQ_IM)
            begin
                x_next = x_reg + SQ_W'(unsigned'(square));
            end
            else
            begin
                if (x_reg >= trial)
                begin
                    x_next    = x_reg - trial;
                    root_next = (root_reg >> 1) + SQ_W'(one_reg);
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                one_next = one_reg >> 2;
            end
            if (step_reg == STEP_ROOT_END)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Operand and working registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            re_reg <= re;
            im_reg <= im;
        end
        x_reg    <= x_next;
        root_reg <= root_next;
        one_reg  <= one_next;
    end

    assign done = done_reg;
    assign mag  = root_reg[MAG_W-1:0];

endmodule

// ----- sv/cvpn_recip.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvpn_recip
// Restoring divider that forms 2^31 / peak one quotient bit per cycle.
// A zero peak yields a zero scale.
// ----------------------------------------------------------------------------
module cvpn_recip
    import cvpn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [MAG_W-1:0]   divisor,
    output logic               done,
    output logic [SCALE_W-1:0] quotient
);

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [DIV_STEP_W-1:0] step_next;
    logic [MAG_W-1:0]      d_reg;
    logic                  zero_reg;
    logic [MAG_W-1:0]      rem_reg;
    logic [MAG_W-1:0]      rem_next;
    logic [SCALE_W-1:0]    dvd_reg;
    logic [SCALE_W-1:0]    dvd_next;
    logic [SCALE_W-1:0]    q_reg;
    logic [SCALE_W-1:0]    q_next;
    logic [MAG_W:0]        trial;
    logic                  q_bit;

    // One shift and subtract per cycle.
    assign trial = {rem_reg, dvd_reg[SCALE_W-1]};
    assign q_bit = (trial >= {1'b0, d_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dvd_next  = RECIP_NUM;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + DIV_STEP_W'(1);
            rem_next  = q_bit ? MAG_W'(trial - {1'b0, d_reg}) : trial[MAG_W-1:0];
            dvd_next  = dvd_reg << 1;
            q_next    = {q_reg[SCALE_W-2:0], q_bit};
            if (step_reg == DIV_STEP_END)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            d_reg    <= divisor;
            zero_reg <= (divisor == '0);
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = zero_reg ? '0 : q_reg;

endmodule

// ----- sv/cvpn_scale.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvpn_scale
// Shared scaling multiplier: registers |x| * scale, truncates by 16 bits
// toward zero, saturates to Q1.15 in the following cycle; y = x at scale 0.
// ----------------------------------------------------------------------------
module cvpn_scale
    import cvpn_pkg::*;
(
    input  logic                       clk,
    input  logic signed [SAMPLE_W-1:0] x,
    input  logic [SCALE_W-1:0]         scale,
    output logic signed [SAMPLE_W-1:0] y
);

    logic [SAMPLE_W:0]          abs_x;
    logic [SAMPLE_W+SCALE_W:0]  prod_full;
    logic [PROD_W-1:0]          prod_reg;
    logic                       neg_reg;
    logic                       pass_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic [PROD_W-17:0]         mag;

    // Magnitude times scale, one multiplier.
    assign abs_x     = x[SAMPLE_W-1] ? (SAMPLE_W+1)'(-$signed({x[SAMPLE_W-1], x}))
                                     : {1'b0, x};
    assign prod_full = (SAMPLE_W+SCALE_W+1)'(abs_x) * (SAMPLE_W+SCALE_W+1)'(scale);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full[PROD_W-1:0];
        neg_reg  <= x[SAMPLE_W-1];
        pass_reg <= (scale == '0);
        x_reg    <= x;
    end

    // Truncate, restore the sign and saturate.
    assign mag = prod_reg[PROD_W-1:16];

    always_comb
    begin
        if (pass_reg)
        begin
            y = x_reg;
        end
        else if (neg_reg)
        begin
            y = (mag >= SAT_NEG_MAG) ? $signed(16'h8000)
                                     : -$signed(mag[SAMPLE_W-1:0]);
        end
        else
        begin
            y = (mag >= SAT_POS_MAG) ? $signed(16'h7FFF) : $signed(mag[SAMPLE_W-1:0]);
        end
    end

endmodule

// ----- sv/complex_vector_peak_normalize_top.sv -----
`timescale 1ns / 1ps
// Each input item is accepted, then passes through the magnitude unit, then updates the peak.
// The final item then also passes the peak through the bit-serial reciprocal unit.
// Each result item then passes through the buffer read and the shared multiplier,
// then waits while the consumer stalls; no new item is accepted until the last result leaves.
// Reset (rst_n, asynchronous, active low) empties the buffer count and clears the peak.
// ----------------------------------------------------------------------------
// complex_vector_peak_normalize_top
// Buffers a complex vector, tracks its peak magnitude and emits every item
// scaled by the reciprocal of that peak.
// ----------------------------------------------------------------------------
`include "complex_vector_peak_normalize_top_assert.svh"

module complex_vector_peak_normalize_top
    import cvpn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // sample_re[15:0], sample_im[31:16]
    input  logic        s_axis_tlast,  // last_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // norm_re[15:0], norm_im[31:16], scale_factor[63:32]
    output logic        m_axis_tlast   // last_result
);

    state_t                     state_reg;
    state_t                     state_next;
    ctrl_t                      ctrl;
    logic [CNT_W-1:0]           fill_reg;
    logic [CNT_W-1:0]           fill_next;
    logic [MAG_W-1:0]           peak_reg;
    logic [MAG_W-1:0]           peak_next;
    logic                       end_reg;
    logic                       end_next;
    logic [ADDR_W-1:0]          idx_reg;
    logic [ADDR_W-1:0]          idx_next;
    logic [SCALE_W-1:0]         scale_reg;
    logic signed [SAMPLE_W-1:0] norm_re_reg;
    logic signed [SAMPLE_W-1:0] norm_im_reg;
    logic                       last_out_reg;
    logic signed [SAMPLE_W-1:0] rd_re_reg;
    logic signed [SAMPLE_W-1:0] rd_im_reg;
    logic signed [SAMPLE_W-1:0] mem_re [MAX_LENGTH];
    logic signed [SAMPLE_W-1:0] mem_im [MAX_LENGTH];
    logic                       in_fire;
    logic                       out_fire;
    logic                       mag_done;
    logic [MAG_W-1:0]           mag;
    logic [MAG_W-1:0]           peak_upd;
    logic                       div_done;
    logic [SCALE_W-1:0]         quotient;
    logic signed [SAMPLE_W-1:0] mul_x;
    logic signed [SAMPLE_W-1:0] scaled;
    logic                       at_last;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign peak_upd = (mag > peak_reg) ? mag : peak_reg;
    assign at_last  = (CNT_W'(idx_reg) + CNT_W'(1) == fill_reg);

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_MAG;
                end
            end
            ST_MAG:
            begin
                if (mag_done)
                begin
                    state_next = end_reg ? ST_DIV : ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:     state_next = ST_MUL_RE;
            ST_MUL_RE: state_next = ST_MUL_IM;
            ST_MUL_IM: state_next = ST_SAT;
            ST_SAT:    state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_fire)
                begin
                    state_next = last_out_reg ? ST_IDLE : ST_RD;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        ctrl           = '0;
        ctrl.in_ready  = (state_reg == ST_IDLE);
        ctrl.mag_start = (state_reg == ST_IDLE) && s_axis_tvalid;
        ctrl.div_start = (state_reg == ST_MAG) && mag_done && end_reg;
        ctrl.rd_en     = (state_reg == ST_RD);
        ctrl.sel_im    = (state_reg == ST_MUL_IM);
        ctrl.load_re   = (state_reg == ST_MUL_IM);
        ctrl.load_im   = (state_reg == ST_SAT);
    end

    assign s_axis_tready = ctrl.in_ready;

    // Vector bookkeeping.
    always_comb
    begin
        fill_next = fill_reg;
        peak_next = peak_reg;
        end_next  = end_reg;
        idx_next  = idx_reg;
        if (in_fire)
        begin
            fill_next = fill_reg + CNT_W'(1);
            end_next  = s_axis_tlast || (fill_reg + CNT_W'(1) == CNT_W'(MAX_LENGTH));
        end
        if (state_reg == ST_MAG && mag_done)
        begin
            peak_next = peak_upd;
        end
        if (state_reg == ST_DIV && div_done)
        begin
            idx_next = '0;
        end
        if (out_fire)
        begin
            if (last_out_reg)
            begin
                fill_next = '0;
                peak_next = '0;
                end_next  = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + ADDR_W'(1);
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            peak_reg  <= '0;
            end_reg   <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            peak_reg  <= peak_next;
            end_reg   <= end_next;
            idx_reg   <= idx_next;
        end
    end

    // Sample buffer: written on accept, read with a registered port.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mem_re[fill_reg[ADDR_W-1:0]] <= s_axis_tdata[15:0];
            mem_im[fill_reg[ADDR_W-1:0]] <= s_axis_tdata[31:16];
        end
        if (ctrl.rd_en)
        begin
            rd_re_reg <= mem_re[idx_reg];
            rd_im_reg <= mem_im[idx_reg];
        end
    end

    // Result registers.
    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            scale_reg <= quotient;
        end
        if (ctrl.load_re)
        begin
            norm_re_reg <= scaled;
        end
        if (ctrl.load_im)
        begin
            norm_im_reg  <= scaled;
            last_out_reg <= at_last;
        end
    end

    // Magnitude of each accepted item.
    cvpn_mag u_mag (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctrl.mag_start),
        .re    (s_axis_tdata[15:0]),
        .im    (s_axis_tdata[31:16]),
        .done  (mag_done),
        .mag   (mag)
    );

    // Reciprocal of the peak.
    cvpn_recip u_recip (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .divisor  (peak_upd),
        .done     (div_done),
        .quotient (quotient)
    );

    // Shared scaling multiplier.
    assign mul_x = ctrl.sel_im ? rd_im_reg : rd_re_reg;

    cvpn_scale u_scale (
        .clk   (clk),
        .x     (mul_x),
        .scale (scale_reg),
        .y     (scaled)
    );

    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {scale_reg, norm_im_reg, norm_re_reg};
    assign m_axis_tlast  = last_out_reg;

    // Checks on the vector bookkeeping.
    `CVPN_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_reg <= CNT_W'(MAX_LENGTH), "fill count beyond buffer depth")
    `CVPN_ASSERT_NOW(a_out_has_data, clk, rst_n, m_axis_tvalid, fill_reg != '0, "result item with an empty buffer")
    `CVPN_ASSERT_NEXT(a_vec_clear, clk, rst_n, out_fire && m_axis_tlast, (fill_reg == '0) && (peak_reg == '0) && (state_reg == ST_IDLE), "vector state not cleared after last result")
    `CVPN_ASSERT_NOW(a_mag_done_state, clk, rst_n, mag_done, state_reg == ST_MAG, "magnitude finished outside its wait state")

endmodule
